FILE: sv/assert_macros.svh
// Assertion macros for the RTL, included by closest_point_on_triangle.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

FILE: sv/cpt_pkg.sv
// Types, widths and constants for the closest-point-on-triangle pipeline
package cpt_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int EW  = CW + 1;        // coordinate difference width
  localparam int PW  = 2 * EW;        // one coordinate product
  localparam int DW  = PW + 2;        // dot product of two differences
  localparam int HW  = DW / 2;        // split point of the wide multiplier
  localparam int XW  = 2 * DW;        // product of two dot products
  localparam int VW  = XW + 4;        // sub-determinants and their sum
  localparam int WB  = 30;            // weight fraction bits
  localparam int TW  = WB + 1;        // weight width, holds 1.0
  localparam int MW  = EW + TW + 1;   // direction times weight
  localparam int AW  = MW + 2;        // point accumulator
  localparam int DIV_STAGES = WB;     // one quotient bit per stage
  localparam int LAT = 13 + DIV_STAGES;

  localparam logic [TW-1:0] ONE_W = TW'(1) << WB;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [XW-1:0] xprod_t;
  typedef logic signed [VW-1:0] wide_t;
  typedef logic signed [MW-1:0] pm_t;
  typedef logic [TW-1:0]        weight_t;
  typedef logic [WB-1:0]        quot_t;

  typedef enum logic [2:0] {
    RGN_A, RGN_B, RGN_AB, RGN_C, RGN_AC, RGN_BC, RGN_IN
  } region_t;

  typedef struct packed {
    coord_t a_x; coord_t a_y; coord_t a_z;
    coord_t b_x; coord_t b_y; coord_t b_z;
    coord_t c_x; coord_t c_y; coord_t c_z;
  } in_t;

  typedef struct packed {
    coord_t     near_x;
    coord_t     near_y;
    coord_t     near_z;
    weight_t    weight_a;
    weight_t    weight_b;
    weight_t    weight_c;
    logic [2:0] region;
    logic       degenerate;
  } out_t;

  typedef struct packed { coord_t x; coord_t y; coord_t z; } vec_t;
  typedef struct packed { diff_t x; diff_t y; diff_t z; } dvec_t;
  typedef struct packed { prod_t x; prod_t y; prod_t z; } pvec_t;
  typedef struct packed { pm_t x; pm_t y; pm_t z; } mvec_t;

  typedef struct packed { vec_t a; vec_t b; vec_t c; } tri_t;

  // Vertices and edge directions, carried down the pipe
  typedef struct packed {
    tri_t  v;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
  } geo_t;

  // Side data that travels alongside the dividers
  typedef struct packed {
    geo_t    g;
    region_t rgn;
    logic    degen;
    logic    zero0;
    logic    one0;
    logic    zero1;
    logic    one1;
  } dside_t;

  // Sign-extend a coordinate to difference width
  function automatic diff_t dext(coord_t v);
    return {v[CW-1], v};
  endfunction

endpackage

FILE: sv/cpt_wmul.sv
// Two-stage signed multiplier for dot-product pairs, built from four partial products
module cpt_wmul import cpt_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  dot_t   a,
  input  dot_t   b,
  output xprod_t p
);

  logic signed [HW-1:0]   ah, bh;
  logic signed [HW:0]     al, bl;
  logic signed [2*HW-1:0] hh;
  logic signed [2*HW:0]   hl, lh;
  logic signed [2*HW+1:0] ll;

  // Split into a signed high half and a zero-extended low half
  assign ah = a[DW-1:HW];
  assign bh = b[DW-1:HW];
  assign al = {1'b0, a[HW-1:0]};
  assign bl = {1'b0, b[HW-1:0]};

  // Register the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= ah * bh;
      hl <= ah * bl;
      lh <= al * bh;
      ll <= al * bl;
    end
  end

  // Combine the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (XW'(hh) <<< (2 * HW)) + ((XW'(hl) + XW'(lh)) <<< HW) + XW'(ll);
    end
  end

endmodule

FILE: sv/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, for 0 < num < den
module cpt_div import cpt_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] num,
  input  logic [VW-1:0] den,
  output quot_t         q
);

  logic [VW:0]   rem   [DIV_STAGES];
  logic [VW-1:0] dv    [DIV_STAGES];
  quot_t         qt    [DIV_STAGES];
  logic [VW:0]   rin   [DIV_STAGES];
  logic [VW-1:0] din   [DIV_STAGES];
  quot_t         qin   [DIV_STAGES];
  logic [VW:0]   dbl   [DIV_STAGES];
  logic [VW+1:0] trial [DIV_STAGES];

  // Shift the remainder and try a subtract at every stage
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        rin[i] = {1'b0, num};
        din[i] = den;
        qin[i] = '0;
      end else begin
        rin[i] = rem[i-1];
        din[i] = dv[i-1];
        qin[i] = qt[i-1];
      end
      dbl[i]   = {rin[i][VW-1:0], 1'b0};
      trial[i] = {1'b0, dbl[i]} - {2'b0, din[i]};
    end
  end

  // Keep the difference when it did not go negative
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv[i] <= din[i];
        if (!trial[i][VW+1]) begin
          rem[i] <= trial[i][VW:0];
          qt[i]  <= {qin[i][WB-2:0], 1'b1};
        end else begin
          rem[i] <= dbl[i];
          qt[i]  <= {qin[i][WB-2:0], 1'b0};
        end
      end
    end
  end

  assign q = qt[DIV_STAGES-1];

endmodule

FILE: sv/closest_point_on_triangle.sv
// Closest point on a triangle to the origin: region tests, ratios and point placement
//
// Usage:
//   query carries the three vertices a, b, c in signed Q16.16. A transaction
//   completes when query_valid and query_ready are both high at a clock edge.
//   answer carries the nearest point, the barycentric weights (2^30 = 1.0),
//   the Voronoi region code and the degenerate flag, under answer_valid and
//   answer_ready with the same rule.
// Pipeline:
//   43 register stages: answer_valid rises when an accepted query reaches
//   the last of them. Stages: capture, dot products, two wide multiplier
//   stages, region select, a 30-stage divider (one quotient bit a stage) and
//   the placement multiply. One query is taken every cycle unless stalled.
// Stall:
//   when answer is held and answer_ready is low, the whole pipe freezes and
//   query_ready drops in the same cycle; nothing is lost or repeated.
// Reset:
//   rst clears every stage valid bit; the pipe comes up empty and ready.
`include "assert_macros.svh"

module closest_point_on_triangle import cpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic query_valid,
  output logic query_ready,
  input  in_t  query,
  output logic answer_valid,
  input  logic answer_ready,
  output out_t answer
);

  logic           en;
  logic [LAT-1:0] vld;

  // Advance the whole pipe unless the output is held
  assign en           = !vld[LAT-1] || answer_ready;
  assign query_ready  = en;
  assign answer_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], query_valid};
    end
  end

  // Stage 1: capture the query
  in_t  q1;
  tri_t vtx1;

  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= query;
    end
  end

  always_comb begin
    vtx1.a = '{x: q1.a_x, y: q1.a_y, z: q1.a_z};
    vtx1.b = '{x: q1.b_x, y: q1.b_y, z: q1.b_z};
    vtx1.c = '{x: q1.c_x, y: q1.c_y, z: q1.c_z};
  end

  // Stage 2: edge directions and negated vertices
  geo_t  geo2;
  dvec_t na2, nb2, nc2;

  always_ff @(posedge clk) begin
    if (en) begin
      geo2.v    <= vtx1;
      geo2.ab.x <= dext(vtx1.b.x) - dext(vtx1.a.x);
      geo2.ab.y <= dext(vtx1.b.y) - dext(vtx1.a.y);
      geo2.ab.z <= dext(vtx1.b.z) - dext(vtx1.a.z);
      geo2.ac.x <= dext(vtx1.c.x) - dext(vtx1.a.x);
      geo2.ac.y <= dext(vtx1.c.y) - dext(vtx1.a.y);
      geo2.ac.z <= dext(vtx1.c.z) - dext(vtx1.a.z);
      geo2.bc.x <= dext(vtx1.c.x) - dext(vtx1.b.x);
      geo2.bc.y <= dext(vtx1.c.y) - dext(vtx1.b.y);
      geo2.bc.z <= dext(vtx1.c.z) - dext(vtx1.b.z);
      na2.x <= -dext(vtx1.a.x);
      na2.y <= -dext(vtx1.a.y);
      na2.z <= -dext(vtx1.a.z);
      nb2.x <= -dext(vtx1.b.x);
      nb2.y <= -dext(vtx1.b.y);
      nb2.z <= -dext(vtx1.b.z);
      nc2.x <= -dext(vtx1.c.x);
      nc2.y <= -dext(vtx1.c.y);
      nc2.z <= -dext(vtx1.c.z);
    end
  end

  // Stage 3: per-axis products of the six dot products
  function automatic pvec_t vmul(dvec_t u, dvec_t v);
    pvec_t r;
    r.x = u.x * v.x;
    r.y = u.y * v.y;
    r.z = u.z * v.z;
    return r;
  endfunction

  geo_t  geo3;
  pvec_t pr3 [6];

  always_ff @(posedge clk) begin
    if (en) begin
      geo3   <= geo2;
      pr3[0] <= vmul(geo2.ab, na2);
      pr3[1] <= vmul(geo2.ac, na2);
      pr3[2] <= vmul(geo2.ab, nb2);
      pr3[3] <= vmul(geo2.ac, nb2);
      pr3[4] <= vmul(geo2.ab, nc2);
      pr3[5] <= vmul(geo2.ac, nc2);
    end
  end

  // Stage 4: sum into d1..d6
  geo_t geo4;
  dot_t dd4 [6];

  always_ff @(posedge clk) begin
    if (en) begin
      geo4 <= geo3;
      for (int j = 0; j < 6; j++) begin
        dd4[j] <= DW'(pr3[j].x) + DW'(pr3[j].y) + DW'(pr3[j].z);
      end
    end
  end

  // Stages 5-6: products of dot products
  xprod_t m [6];

  cpt_wmul u_mul0 (.clk(clk), .en(en), .a(dd4[0]), .b(dd4[3]), .p(m[0]));
  cpt_wmul u_mul1 (.clk(clk), .en(en), .a(dd4[2]), .b(dd4[1]), .p(m[1]));
  cpt_wmul u_mul2 (.clk(clk), .en(en), .a(dd4[4]), .b(dd4[1]), .p(m[2]));
  cpt_wmul u_mul3 (.clk(clk), .en(en), .a(dd4[0]), .b(dd4[5]), .p(m[3]));
  cpt_wmul u_mul4 (.clk(clk), .en(en), .a(dd4[2]), .b(dd4[5]), .p(m[4]));
  cpt_wmul u_mul5 (.clk(clk), .en(en), .a(dd4[4]), .b(dd4[3]), .p(m[5]));

  geo_t geo5, geo6;
  dot_t dd5 [6];
  dot_t dd6 [6];

  always_ff @(posedge clk) begin
    if (en) begin
      geo5 <= geo4;
      geo6 <= geo5;
      dd5  <= dd4;
      dd6  <= dd5;
    end
  end

  // Stage 7: sub-determinants and edge numerators
  geo_t  geo7;
  dot_t  d7 [6];
  wide_t vc7, vb7, va7, e43_7, e56_7, s13_7, s26_7, ebc7;

  always_ff @(posedge clk) begin
    if (en) begin
      geo7  <= geo6;
      d7    <= dd6;
      vc7   <= VW'(m[0]) - VW'(m[1]);
      vb7   <= VW'(m[2]) - VW'(m[3]);
      va7   <= VW'(m[4]) - VW'(m[5]);
      e43_7 <= VW'(dd6[3]) - VW'(dd6[2]);
      e56_7 <= VW'(dd6[4]) - VW'(dd6[5]);
      s13_7 <= VW'(dd6[0]) - VW'(dd6[2]);
      s26_7 <= VW'(dd6[1]) - VW'(dd6[5]);
      ebc7  <= VW'(dd6[3]) - VW'(dd6[2]) + VW'(dd6[4]) - VW'(dd6[5]);
    end
  end

  // Stage 8: region tests in order, pick ratio operands
  region_t rg;
  wide_t   den_all, num0, den0, num1, den1;

  always_comb begin
    den_all = va7 + vb7 + vc7;
    num0    = '0;
    den0    = VW'(1);
    num1    = '0;
    den1    = VW'(1);
    rg      = RGN_IN;
    if (d7[0] <= 0 && d7[1] <= 0) begin
      rg = RGN_A;
    end else if (d7[2] >= 0 && e43_7 <= 0) begin
      rg = RGN_B;
    end else if (vc7 <= 0 && d7[0] >= 0 && d7[2] <= 0) begin
      rg   = RGN_AB;
      num0 = VW'(d7[0]);
      den0 = s13_7;
    end else if (d7[5] >= 0 && e56_7 <= 0) begin
      rg = RGN_C;
    end else if (vb7 <= 0 && d7[1] >= 0 && d7[5] <= 0) begin
      rg   = RGN_AC;
      num0 = VW'(d7[1]);
      den0 = s26_7;
    end else if (va7 <= 0 && e43_7 >= 0 && e56_7 >= 0) begin
      rg   = RGN_BC;
      num0 = e43_7;
      den0 = ebc7;
    end else begin
      num0 = vb7;
      den0 = den_all;
      num1 = vc7;
      den1 = den_all;
    end
  end

  geo_t    geo8;
  region_t rgn8;
  wide_t   n0_8, dn0_8, n1_8, dn1_8;

  always_ff @(posedge clk) begin
    if (en) begin
      geo8  <= geo7;
      rgn8  <= rg;
      n0_8  <= num0;
      dn0_8 <= den0;
      n1_8  <= num1;
      dn1_8 <= den1;
    end
  end

  // Stage 9: make denominators positive, flag a zero interior denominator
  geo_t    geo9;
  region_t rgn9;
  logic    degen9;
  wide_t   n0_9, dn0_9, n1_9, dn1_9;

  always_ff @(posedge clk) begin
    if (en) begin
      geo9   <= geo8;
      rgn9   <= rgn8;
      degen9 <= (rgn8 == RGN_IN) && (dn0_8 == '0);
      n0_9   <= (dn0_8 < 0) ? -n0_8  : n0_8;
      dn0_9  <= (dn0_8 < 0) ? -dn0_8 : dn0_8;
      n1_9   <= (dn1_8 < 0) ? -n1_8  : n1_8;
      dn1_9  <= (dn1_8 < 0) ? -dn1_8 : dn1_8;
    end
  end

  // Stage 10: clamp cases, load divider operands
  dside_t        ds10;
  logic [VW-1:0] n0_10, dn0_10, n1_10, dn1_10;

  always_ff @(posedge clk) begin
    if (en) begin
      ds10.g     <= geo9;
      ds10.rgn   <= rgn9;
      ds10.degen <= degen9;
      ds10.zero0 <= (dn0_9 == '0) || (n0_9 <= 0);
      ds10.one0  <= (n0_9 >= dn0_9);
      ds10.zero1 <= (dn1_9 == '0) || (n1_9 <= 0);
      ds10.one1  <= (n1_9 >= dn1_9);
      n0_10      <= n0_9;
      dn0_10     <= dn0_9;
      n1_10      <= n1_9;
      dn1_10     <= dn1_9;
    end
  end

  // Stages 11-40: dividers, side data delayed alongside
  quot_t  quo0, quo1;
  dside_t dly [DIV_STAGES];

  cpt_div u_div0 (.clk(clk), .en(en), .num(n0_10), .den(dn0_10), .q(quo0));
  cpt_div u_div1 (.clk(clk), .en(en), .num(n1_10), .den(dn1_10), .q(quo1));

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= ds10;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // Stage 41: weights and placement operands per region
  dside_t        dd;
  weight_t       t0, t1, wa, wb, wc, pt1, pt2, wfix;
  logic [TW:0]   vw_sum;
  vec_t          base;
  dvec_t         dir1, dir2;

  always_comb begin
    dd     = dly[DIV_STAGES-1];
    t0     = dd.zero0 ? '0 : (dd.one0 ? ONE_W : {1'b0, quo0});
    t1     = dd.zero1 ? '0 : (dd.one1 ? ONE_W : {1'b0, quo1});
    vw_sum = {1'b0, t0} + {1'b0, t1};
    wfix   = (vw_sum > {1'b0, ONE_W}) ? ONE_W - t0 : t1;
    wa     = ONE_W;
    wb     = '0;
    wc     = '0;
    base   = dd.g.v.a;
    dir1   = dd.g.ab;
    dir2   = dd.g.ac;
    pt1    = '0;
    pt2    = '0;
    case (dd.rgn)
      RGN_A: begin
      end
      RGN_B: begin
        wa   = '0;
        wb   = ONE_W;
        base = dd.g.v.b;
      end
      RGN_AB: begin
        wa  = ONE_W - t0;
        wb  = t0;
        pt1 = t0;
      end
      RGN_C: begin
        wa   = '0;
        wc   = ONE_W;
        base = dd.g.v.c;
      end
      RGN_AC: begin
        wa   = ONE_W - t0;
        wc   = t0;
        dir1 = dd.g.ac;
        dir2 = dd.g.ab;
        pt1  = t0;
      end
      RGN_BC: begin
        wa   = '0;
        wb   = ONE_W - t0;
        wc   = t0;
        base = dd.g.v.b;
        dir1 = dd.g.bc;
        dir2 = dd.g.ab;
        pt1  = t0;
      end
      RGN_IN: begin
        if (!dd.degen) begin
          wa  = ONE_W - t0 - wfix;
          wb  = t0;
          wc  = wfix;
          pt1 = t0;
          pt2 = wfix;
        end
      end
      default: begin
      end
    endcase
  end

  region_t rgn41;
  logic    degen41;
  weight_t wa41, wb41, wc41, pt1_41, pt2_41;
  vec_t    base41;
  dvec_t   dir1_41, dir2_41;

  always_ff @(posedge clk) begin
    if (en) begin
      rgn41   <= dd.rgn;
      degen41 <= dd.degen;
      wa41    <= wa;
      wb41    <= wb;
      wc41    <= wc;
      pt1_41  <= pt1;
      pt2_41  <= pt2;
      base41  <= base;
      dir1_41 <= dir1;
      dir2_41 <= dir2;
    end
  end

  // Stage 42: direction times weight
  function automatic mvec_t wmulv(dvec_t d, weight_t t);
    mvec_t r;
    r.x = d.x * $signed({1'b0, t});
    r.y = d.y * $signed({1'b0, t});
    r.z = d.z * $signed({1'b0, t});
    return r;
  endfunction

  region_t rgn42;
  logic    degen42;
  weight_t wa42, wb42, wc42;
  vec_t    base42;
  mvec_t   p1_42, p2_42;

  always_ff @(posedge clk) begin
    if (en) begin
      rgn42   <= rgn41;
      degen42 <= degen41;
      wa42    <= wa41;
      wb42    <= wb41;
      wc42    <= wc41;
      base42  <= base41;
      p1_42   <= wmulv(dir1_41, pt1_41);
      p2_42   <= wmulv(dir2_41, pt2_41);
    end
  end

  // Stage 43: round, add base, drive the output register
  logic signed [AW-1:0] accx, accy, accz, px, py, pz;

  always_comb begin
    accx = AW'(p1_42.x) + AW'(p2_42.x) + (AW'(1) <<< (WB - 1));
    accy = AW'(p1_42.y) + AW'(p2_42.y) + (AW'(1) <<< (WB - 1));
    accz = AW'(p1_42.z) + AW'(p2_42.z) + (AW'(1) <<< (WB - 1));
    px   = AW'(base42.x) + (accx >>> WB);
    py   = AW'(base42.y) + (accy >>> WB);
    pz   = AW'(base42.z) + (accz >>> WB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      answer.near_x     <= px[CW-1:0];
      answer.near_y     <= py[CW-1:0];
      answer.near_z     <= pz[CW-1:0];
      answer.weight_a   <= wa42;
      answer.weight_b   <= wb42;
      answer.weight_c   <= wc42;
      answer.region     <= rgn42;
      answer.degenerate <= degen42;
    end
  end

  // Checks
  logic [TW+1:0] wsum;
  logic          degen_ok;

  assign wsum     = {2'b0, answer.weight_a} + {2'b0, answer.weight_b} + {2'b0, answer.weight_c};
  assign degen_ok = (answer.region == RGN_IN) && (answer.weight_a == ONE_W);

  `ASSERT_IMPLIES(a_wsum, clk, rst, answer_valid, wsum == {2'b0, ONE_W})
  `ASSERT_IMPLIES(a_degen, clk, rst, answer_valid && answer.degenerate, degen_ok)
  `ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vld))

endmodule
